@@ rtl/sdii_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdii_pkg;

    // running sums and line store entries
    localparam int SUM_W = 38;
    // integral value as seen on the port
    localparam int OUT_W = 37;
    // configuration data width
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_WIDTH   = 2'd0,
        REG_BLOCK_HEIGHT  = 2'd1,
        REG_EXPONENT_MODE = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

@@ rtl/sdii_term.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdii_term import sdii_pkg::*; #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic [PIXEL_BITS-1:0] i_pixel_ref,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_shifted,
    input  wire logic                  i_shifted_inside,
    input  wire logic                  i_exponent_mode,
    output logic      [SUM_W-1:0]      o_term
);

    logic [PIXEL_BITS:0]     diff;
    logic [PIXEL_BITS-1:0]   mag;
    logic [2*PIXEL_BITS-1:0] sq;

    always_comb begin
        diff = {1'b0, i_pixel_ref} - {1'b0, i_pixel_shifted};
        // magnitude without going through the sign bit
        mag  = diff[PIXEL_BITS] ? (i_pixel_shifted - i_pixel_ref)
                                : (i_pixel_ref - i_pixel_shifted);
        sq   = {{PIXEL_BITS{1'b0}}, mag} * {{PIXEL_BITS{1'b0}}, mag};
        if (!i_shifted_inside) begin
            o_term = '0;
        end else if (i_exponent_mode) begin
            o_term = {{(SUM_W-2*PIXEL_BITS){1'b0}}, sq};
        end else begin
            o_term = {{(SUM_W-PIXEL_BITS-1){diff[PIXEL_BITS]}}, diff};
        end
    end

endmodule

`default_nettype wire

@@ rtl/shifted_difference_integral_image_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------------
// in       | i_in_valid / o_in_ready   | pixel_ref, pixel_shifted, shifted_inside,
//          |                           | block_start
// out      | o_out_valid / i_out_ready | integral_value, last_of_block
// cfg      | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// one pixel per cycle while the output is not stalled; a result passes through stage 1
// and the output register; the line store is read at the accept edge and written as the
// item leaves stage 1; a same-column write at that read edge (width 1) is forwarded
// synchronous active-low reset clears counters, running sum and handshake state,
// no clearing pass over the line store
// a stalled output holds one result, and one more pixel can enter before o_in_ready drops

module shifted_difference_integral_image_top import sdii_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [PIXEL_BITS-1:0]   i_pixel_ref,
    input  wire logic [PIXEL_BITS-1:0]   i_pixel_shifted,
    input  wire logic                    i_shifted_inside,
    input  wire logic                    i_block_start,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [OUT_W-1:0]      o_integral_value,
    output logic                         o_last_of_block
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int RCNT_W = $clog2(MAX_HEIGHT);
    localparam int SZ_W   = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
    localparam int SZH_W  = (RCNT_W + 1 > CFG_W) ? RCNT_W + 1 : CFG_W;

    // configuration
    logic [CFG_W-1:0] r_block_width;
    logic [CFG_W-1:0] r_block_height;
    logic             r_exponent_mode;

    // stage 0 state
    logic [CNT_W-1:0]  r_col;
    logic [RCNT_W-1:0] r_row;
    logic [SUM_W-1:0]  r_row_sum;

    // stage 1: line store read in flight
    logic              r_s1_vld;
    logic [CNT_W-1:0]  r_s1_col;
    logic              r_s1_row_nz;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s1_last;
    logic [SUM_W-1:0]  r_rdata;
    logic              r_fwd;
    logic [SUM_W-1:0]  r_fwd_val;

    // output register
    logic              r_out_vld;
    logic [OUT_W-1:0]  r_out_val;
    logic              r_out_last;

    logic [SUM_W-1:0]  mem_line [MAX_WIDTH];

    logic [SZ_W-1:0]   w_eff;
    logic [SZH_W-1:0]  h_eff;
    logic [CNT_W-1:0]  col0;
    logic [RCNT_W-1:0] row0;
    logic [SUM_W-1:0]  term;
    logic [SUM_W-1:0]  row_sum;
    logic              end_row;
    logic              end_blk;
    logic              in_acc;
    logic              s1_adv;
    logic              s1_wr;
    logic [SUM_W-1:0]  above;
    logic [SUM_W-1:0]  s1_value;

    sdii_term #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_term (
        .i_pixel_ref      (i_pixel_ref),
        .i_pixel_shifted  (i_pixel_shifted),
        .i_shifted_inside (i_shifted_inside),
        .i_exponent_mode  (r_exponent_mode),
        .o_term           (term)
    );

    always_comb begin
        // a size of zero counts as one, anything above the maximum as the maximum
        if (r_block_width == '0) begin
            w_eff = SZ_W'(1);
        end else if (SZ_W'(r_block_width) > SZ_W'(MAX_WIDTH)) begin
            w_eff = SZ_W'(MAX_WIDTH);
        end else begin
            w_eff = SZ_W'(r_block_width);
        end
        if (r_block_height == '0) begin
            h_eff = SZH_W'(1);
        end else if (SZH_W'(r_block_height) > SZH_W'(MAX_HEIGHT)) begin
            h_eff = SZH_W'(MAX_HEIGHT);
        end else begin
            h_eff = SZH_W'(r_block_height);
        end

        col0    = i_block_start ? '0 : r_col;
        row0    = i_block_start ? '0 : r_row;
        row_sum = ((col0 == '0) ? '0 : r_row_sum) + term;
        end_row = (SZ_W'(col0) + SZ_W'(1)) >= w_eff;
        end_blk = end_row && ((SZH_W'(row0) + SZH_W'(1)) >= h_eff);

        s1_adv  = !r_out_vld || i_out_ready;
        s1_wr   = r_s1_vld && s1_adv;
        above   = r_s1_row_nz ? (r_fwd ? r_fwd_val : r_rdata) : '0;
        s1_value = above + r_s1_sum;

        o_in_ready = !r_s1_vld || s1_adv;
        in_acc     = i_in_valid && o_in_ready;
    end

    assign o_out_valid      = r_out_vld;
    assign o_integral_value = r_out_val;
    assign o_last_of_block  = r_out_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_width   <= CFG_W'(1024);
            r_block_height  <= CFG_W'(1024);
            r_exponent_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_BLOCK_WIDTH:   r_block_width   <= i_cfg_data;
                REG_BLOCK_HEIGHT:  r_block_height  <= i_cfg_data;
                REG_EXPONENT_MODE: r_exponent_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // counters, running sum and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_row_sum <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_row_sum <= row_sum;
                if (end_row) begin
                    r_col <= '0;
                    r_row <= end_blk ? '0 : row0 + RCNT_W'(1);
                end else begin
                    r_col <= col0 + CNT_W'(1);
                    r_row <= row0;
                end
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_wr) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col    <= col0;
            r_s1_row_nz <= (row0 != '0);
            r_s1_sum    <= row_sum;
            r_s1_last   <= end_blk;
            // write of the item ahead lands on the column being read
            r_fwd       <= s1_wr && (r_s1_col == col0);
            r_fwd_val   <= s1_value;
        end
        if (s1_wr) begin
            r_out_val  <= s1_value[OUT_W-1:0];
            r_out_last <= r_s1_last;
        end
    end

    // line store of the previous row's integral values
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= mem_line[col0];
        end
        if (s1_wr) begin
            mem_line[r_s1_col] <= s1_value;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sdii_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdii_checker import sdii_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [OUT_W-1:0] o_integral_value,
    input wire logic                    o_last_of_block
);

    logic [1:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // transactions taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_pending_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two transactions held inside");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 2'd0)
        else $error("result without a pending transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_integral_value) && $stable(o_last_of_block))
        else $error("stalled result changed");

endmodule

bind shifted_difference_integral_image_top sdii_checker u_sdii_checker (.*);

`default_nettype wire
